/* rtl/core/owbm_pkg.sv */
`timescale 1ns / 1ps

package owbm_pkg;

   // Width of every timing register and of the tick counter.
   localparam int TimerBits = 12;
   // Number of bus lines that the channel field may select.
   localparam int NumLines = 2;
   localparam int NumRegs = 8;
   localparam int CsrIndexBits = $clog2(NumRegs);

   // Command codes carried in the action field.
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_RESET = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   // Register indexes on the configuration port.
   localparam int REG_RESET_LOW       = 0;
   localparam int REG_PRESENCE_SAMPLE = 1;
   localparam int REG_PRESENCE_WINDOW = 2;
   localparam int REG_SLOT            = 3;
   localparam int REG_WRITE_ONE_LOW   = 4;
   localparam int REG_READ_LOW        = 5;
   localparam int REG_READ_SAMPLE     = 6;
   localparam int REG_RECOVERY        = 7;

   typedef logic [TimerBits-1:0] timer_type;
   typedef timer_type reg_array_type [NumRegs];

   localparam reg_array_type RegDefaults = '{
      TimerBits'(600), TimerBits'(80), TimerBits'(600), TimerBits'(80),
      TimerBits'(2), TimerBits'(2), TimerBits'(10), TimerBits'(5)
   };

   typedef struct packed {
      logic       drive_low;
      logic       active_channel;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_data;
   } result_type;

   // A low time of zero still lasts one tick.
   function automatic timer_type at_least_one(input timer_type value);
      timer_type result;
      result = (value == '0) ? timer_type'(1) : value;
      return result;
   endfunction

endpackage

/* rtl/core/owbm_if.sv */
`timescale 1ns / 1ps

interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] write_byte;
   logic       channel;
   logic       line_level;

   modport source (output valid, action, write_byte, channel, line_level, input ready);
   modport sink (input valid, action, write_byte, channel, line_level, output ready);
endinterface

interface owbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       active_channel;
   logic       busy_res;
   logic       done_res;
   logic       presence;
   logic [7:0] read_data;

   modport source (output valid, drive_low, active_channel, busy_res, done_res, presence,
                   read_data, input ready);
   modport sink (input valid, drive_low, active_channel, busy_res, done_res, presence,
                 read_data, output ready);
endinterface

interface owbm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [owbm_pkg::CsrIndexBits-1:0] index;
   logic [owbm_pkg::TimerBits-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/owbm_csr.sv */
`timescale 1ns / 1ps

module owbm_csr (
   input  logic                    clock,
   input  logic                    reset,
   owbm_csr_if.sink                csr_if,
   output owbm_pkg::reg_array_type regs
);

   owbm_pkg::reg_array_type regs_ff;

   assign csr_if.ready = 1'b1;
   assign regs = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= owbm_pkg::RegDefaults;
      end else if (csr_if.valid) begin
         regs_ff[csr_if.index] <= csr_if.data;
      end
   end

endmodule

/* rtl/core/owbm_core.sv */
`timescale 1ns / 1ps

module owbm_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              action,
   input  logic [7:0]              write_byte,
   input  logic                    channel,
   input  logic                    line_level,
   input  owbm_pkg::reg_array_type regs,
   output owbm_pkg::result_type    result
);

   localparam int TB = owbm_pkg::TimerBits;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_REL,
      PH_SLOT_LOW,
      PH_SLOT_REL,
      PH_RECOVER
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [TB-1:0]       count_ff, count_in;
   logic [2:0]          bit_index_ff, bit_index_in;
   logic [7:0]          shift_byte_ff, shift_byte_in;
   logic [1:0]          op_kind_ff, op_kind_in;
   logic                presence_flag_ff, presence_flag_in;
   logic                channel_ff, channel_in;

   logic                start;
   phase_type           cur_phase;
   logic [TB-1:0]       cur_count;
   logic [TB:0]         count_inc;
   logic                cur_bit;
   logic                is_read;
   logic                end_of_slot;
   logic [TB:0]         lo_write_one, lo_read, lo_slot, slot_len;
   logic [TB:0]         rel_read_raw, rel_read, rel_write, sample_plus;
   logic [TB:0]         len_rst_rel, len_slot_low, len_slot_rel, cur_len;
   owbm_pkg::result_type result_c;

   assign start = accept && (phase_ff == PH_IDLE) && (action != owbm_pkg::ACT_TICK);
   assign result = result_c;

   // Slot and reset phase lengths, one bit wider than the registers.
   always_comb begin
      lo_write_one = {1'b0, owbm_pkg::at_least_one(regs[owbm_pkg::REG_WRITE_ONE_LOW])};
      lo_read      = {1'b0, owbm_pkg::at_least_one(regs[owbm_pkg::REG_READ_LOW])};
      lo_slot      = {1'b0, owbm_pkg::at_least_one(regs[owbm_pkg::REG_SLOT])};
      slot_len     = {1'b0, regs[owbm_pkg::REG_SLOT]};
      sample_plus  = {1'b0, regs[owbm_pkg::REG_PRESENCE_SAMPLE]} + 1'b1;
      len_rst_rel  = ({1'b0, regs[owbm_pkg::REG_PRESENCE_WINDOW]} > sample_plus) ?
                     {1'b0, regs[owbm_pkg::REG_PRESENCE_WINDOW]} : sample_plus;
      rel_read_raw = (slot_len > lo_read) ? (slot_len - lo_read) : '0;
      rel_read     = (rel_read_raw > ({1'b0, regs[owbm_pkg::REG_READ_SAMPLE]} + 1'b1)) ?
                     rel_read_raw : ({1'b0, regs[owbm_pkg::REG_READ_SAMPLE]} + 1'b1);
      rel_write    = (slot_len > lo_write_one) ? (slot_len - lo_write_one) : '0;
   end

   always_comb begin
      // Apply a command that starts on this tick before the tick itself is run.
      cur_phase        = phase_ff;
      cur_count        = count_ff;
      bit_index_in     = bit_index_ff;
      shift_byte_in    = shift_byte_ff;
      op_kind_in       = op_kind_ff;
      presence_flag_in = presence_flag_ff;
      channel_in       = channel_ff;
      if (start) begin
         cur_count    = '0;
         bit_index_in = '0;
         op_kind_in   = action;
         if (int'(channel) >= owbm_pkg::NumLines) begin
            channel_in = 1'(owbm_pkg::NumLines - 1);
         end else begin
            channel_in = channel;
         end
         if (action == owbm_pkg::ACT_RESET) begin
            presence_flag_in = 1'b0;
            shift_byte_in    = '0;
            cur_phase        = PH_RST_LOW;
         end else begin
            shift_byte_in = (action == owbm_pkg::ACT_WRITE) ? write_byte : 8'd0;
            cur_phase     = PH_SLOT_LOW;
         end
      end

      is_read = (op_kind_in == owbm_pkg::ACT_READ);

      if (cur_phase == PH_RST_REL && cur_count == regs[owbm_pkg::REG_PRESENCE_SAMPLE]) begin
         presence_flag_in = !line_level;
      end
      if (cur_phase == PH_SLOT_REL && is_read &&
          cur_count == regs[owbm_pkg::REG_READ_SAMPLE]) begin
         shift_byte_in[bit_index_in] = line_level;
      end

      cur_bit      = shift_byte_in[bit_index_in];
      len_slot_low = is_read ? lo_read : (cur_bit ? lo_write_one : lo_slot);
      len_slot_rel = is_read ? rel_read : (cur_bit ? rel_write : '0);

      unique case (cur_phase)
         PH_RST_LOW:  cur_len = {1'b0, owbm_pkg::at_least_one(regs[owbm_pkg::REG_RESET_LOW])};
         PH_RST_REL:  cur_len = len_rst_rel;
         PH_SLOT_LOW: cur_len = len_slot_low;
         PH_SLOT_REL: cur_len = len_slot_rel;
         PH_RECOVER:  cur_len = {1'b0, regs[owbm_pkg::REG_RECOVERY]};
         default:     cur_len = '0;
      endcase

      count_inc   = {1'b0, cur_count} + 1'b1;
      phase_in    = cur_phase;
      count_in    = count_inc[TB-1:0];
      end_of_slot = 1'b0;
      result_c    = '0;
      result_c.active_channel = channel_in;

      if (cur_phase != PH_IDLE) begin
         result_c.busy_res  = 1'b1;
         result_c.drive_low = (cur_phase == PH_RST_LOW) || (cur_phase == PH_SLOT_LOW);
         if (count_inc >= cur_len) begin
            // Phases of zero length are passed over within the same tick.
            count_in = '0;
            unique case (cur_phase)
               PH_RST_LOW: phase_in = PH_RST_REL;
               PH_RST_REL: phase_in = PH_IDLE;
               PH_SLOT_LOW: begin
                  if (len_slot_rel != '0) begin
                     phase_in = PH_SLOT_REL;
                  end else if (regs[owbm_pkg::REG_RECOVERY] != '0) begin
                     phase_in = PH_RECOVER;
                  end else begin
                     end_of_slot = 1'b1;
                  end
               end
               PH_SLOT_REL: begin
                  if (regs[owbm_pkg::REG_RECOVERY] != '0) begin
                     phase_in = PH_RECOVER;
                  end else begin
                     end_of_slot = 1'b1;
                  end
               end
               default: end_of_slot = 1'b1;
            endcase
            if (end_of_slot) begin
               if (bit_index_in == 3'd7) begin
                  phase_in = PH_IDLE;
               end else begin
                  bit_index_in = bit_index_in + 3'd1;
                  phase_in     = PH_SLOT_LOW;
               end
            end
            if (phase_in == PH_IDLE) begin
               result_c.done_res = 1'b1;
               if (op_kind_in == owbm_pkg::ACT_RESET) begin
                  result_c.presence = presence_flag_in;
               end
               if (is_read) begin
                  result_c.read_data = shift_byte_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         count_ff         <= '0;
         bit_index_ff     <= '0;
         shift_byte_ff    <= '0;
         op_kind_ff       <= '0;
         presence_flag_ff <= 1'b0;
         channel_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         count_ff         <= count_in;
         bit_index_ff     <= bit_index_in;
         shift_byte_ff    <= shift_byte_in;
         op_kind_ff       <= op_kind_in;
         presence_flag_ff <= presence_flag_in;
         channel_ff       <= channel_in;
      end
   end

endmodule

/* rtl/core/onewire_bus_master_timing_unit.sv */
`timescale 1ns / 1ps

// Channel   Dir  Payload
// req_if    in   action, write_byte, channel, line_level (one tick per transfer)
// rsp_if    out  drive_low, active_channel, busy_res, done_res, presence, read_data
// csr_if    in   index, data (timing register write, always ready)
//
// Every accepted tick yields one result, registered for the next cycle; one tick can
// be taken in every cycle while results drain. The phase sequencer sets the rate,
// stepping once per accepted tick. A new tick is taken while the result register is
// empty or drained in the same cycle, so a stalled result holds the request side.
// Reset is synchronous and restores the default timing and the idle phase.
module onewire_bus_master_timing_unit (
   input  logic       clock,
   input  logic       reset,
   owbm_req_if.sink   req_if,
   owbm_rsp_if.source rsp_if,
   owbm_csr_if.sink   csr_if
);

   owbm_pkg::reg_array_type regs;
   owbm_pkg::result_type    result;
   owbm_pkg::result_type    rsp_data_ff;
   logic                    rsp_valid_ff;
   logic                    req_ready;
   logic                    accept;

   assign req_ready    = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = req_ready;
   assign accept       = req_if.valid && req_ready;

   owbm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .regs   (regs)
   );

   owbm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_if.action),
      .write_byte (req_if.write_byte),
      .channel    (req_if.channel),
      .line_level (req_if.line_level),
      .regs       (regs),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.drive_low      = rsp_data_ff.drive_low;
   assign rsp_if.active_channel = rsp_data_ff.active_channel;
   assign rsp_if.busy_res       = rsp_data_ff.busy_res;
   assign rsp_if.done_res       = rsp_data_ff.done_res;
   assign rsp_if.presence       = rsp_data_ff.presence;
   assign rsp_if.read_data      = rsp_data_ff.read_data;

endmodule

/* bench/onewire_bus_master_timing_unit_tb.sv */
`timescale 1ns / 1ps

module onewire_bus_master_timing_unit_tb;

   localparam int IdleLimit = 2000;
   localparam int IndexBits = owbm_pkg::CsrIndexBits;

   typedef enum logic [2:0] {
      BUS_IDLE,
      BUS_RST_LOW,
      BUS_RST_REL,
      BUS_SLOT_LOW,
      BUS_SLOT_REL,
      BUS_RECOVER
   } bus_phase_type;

   typedef struct packed {
      logic [1:0]           action;
      logic [7:0]           write_byte;
      logic                 channel;
      logic                 line_level;
      logic                 typed;
      owbm_pkg::result_type want;
   } tick_row_type;

   localparam owbm_pkg::result_type Predicted = '0;

   // Timing registers all at zero while this runs: every low phase lasts one tick,
   // a reset takes two ticks, a written bit one tick and a read bit two ticks.
   localparam tick_row_type Script [28] = '{
      '{owbm_pkg::ACT_TICK,  8'hFF, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
      '{owbm_pkg::ACT_RESET, 8'h00, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
      '{owbm_pkg::ACT_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00}},
      '{owbm_pkg::ACT_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_READ,  8'hFF, 1'b1, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_RESET, 8'h55, 1'b1, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_READ,  8'hAA, 1'b0, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_READ,  8'h01, 1'b1, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_RESET, 8'h80, 1'b0, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_READ,  8'hFF, 1'b1, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_READ,  8'h5A, 1'b1, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_TICK,  8'h00, 1'b0, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_RESET, 8'h00, 1'b0, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_TICK,  8'hFF, 1'b0, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_READ,  8'h00, 1'b0, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_RESET, 8'hFF, 1'b1, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_WRITE, 8'h00, 1'b1, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_TICK,  8'h00, 1'b0, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_READ,  8'hFF, 1'b0, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_RESET, 8'h00, 1'b0, 1'b0, 1'b0, Predicted},
      '{owbm_pkg::ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, Predicted},
      '{owbm_pkg::ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}}
   };

   logic clock = 1'b0;
   logic reset;

   owbm_req_if req_if ();
   owbm_rsp_if rsp_if ();
   owbm_csr_if csr_if ();

   onewire_bus_master_timing_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #10 clock = ~clock;

   // Model of the bus master, stepped once per accepted tick.
   owbm_pkg::reg_array_type timing = owbm_pkg::RegDefaults;
   bus_phase_type bus_phase = BUS_IDLE;
   int unsigned tick_cnt = 0;
   int unsigned bit_pos = 0;
   logic [7:0] shift_reg = '0;
   logic [1:0] op_kind = owbm_pkg::ACT_TICK;
   logic presence_seen = 1'b0;
   logic line_sel = 1'b0;

   owbm_pkg::result_type pending_bus_results[$];
   int gap_pct = 0;
   int stall_pct = 0;
   int failures = 0;
   int results_seen = 0;
   int ticks_sent = 0;
   int ops_finished = 0;
   int settings_used = 0;
   int idle_cycles = 0;

   function automatic int unsigned low_ticks(input owbm_pkg::timer_type value);
      return (value == '0) ? 1 : int'(value);
   endfunction

   function automatic int unsigned phase_ticks(input bus_phase_type ph);
      int unsigned slot;
      int unsigned lo;
      int unsigned rel;
      slot = timing[owbm_pkg::REG_SLOT];
      case (ph)
         BUS_RST_LOW: return low_ticks(timing[owbm_pkg::REG_RESET_LOW]);
         BUS_RST_REL: begin
            rel = timing[owbm_pkg::REG_PRESENCE_SAMPLE] + 1;
            return (timing[owbm_pkg::REG_PRESENCE_WINDOW] > rel) ?
                   timing[owbm_pkg::REG_PRESENCE_WINDOW] : rel;
         end
         BUS_SLOT_LOW: begin
            if (op_kind == owbm_pkg::ACT_READ) return low_ticks(timing[owbm_pkg::REG_READ_LOW]);
            return shift_reg[bit_pos] ? low_ticks(timing[owbm_pkg::REG_WRITE_ONE_LOW]) :
                                        low_ticks(slot);
         end
         BUS_SLOT_REL: begin
            if (op_kind == owbm_pkg::ACT_READ) begin
               lo = low_ticks(timing[owbm_pkg::REG_READ_LOW]);
               rel = (slot > lo) ? slot - lo : 0;
               return (rel > timing[owbm_pkg::REG_READ_SAMPLE] + 1) ?
                      rel : timing[owbm_pkg::REG_READ_SAMPLE] + 1;
            end
            if (!shift_reg[bit_pos]) return 0;
            lo = low_ticks(timing[owbm_pkg::REG_WRITE_ONE_LOW]);
            return (slot > lo) ? slot - lo : 0;
         end
         BUS_RECOVER: return timing[owbm_pkg::REG_RECOVERY];
         default: return 0;
      endcase
   endfunction

   // Steps past the end of the current phase, skipping empty ones.
   // Returns 1 when the operation is over.
   function automatic bit leave_phase();
      int hop;
      for (hop = 0; hop < 6; hop++) begin
         case (bus_phase)
            BUS_RST_LOW: bus_phase = BUS_RST_REL;
            BUS_SLOT_LOW: bus_phase = BUS_SLOT_REL;
            BUS_SLOT_REL: bus_phase = BUS_RECOVER;
            BUS_RECOVER: begin
               if (bit_pos >= 7) begin
                  bus_phase = BUS_IDLE;
                  return 1'b1;
               end
               bit_pos = bit_pos + 1;
               bus_phase = BUS_SLOT_LOW;
            end
            default: begin
               bus_phase = BUS_IDLE;
               return 1'b1;
            end
         endcase
         tick_cnt = 0;
         if (phase_ticks(bus_phase) != 0) return 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic owbm_pkg::result_type predict_tick(input logic [1:0] act,
                                                         input logic [7:0] wbyte,
                                                         input logic chan, input logic level);
      owbm_pkg::result_type r;
      r = '0;
      if (bus_phase == BUS_IDLE && act != owbm_pkg::ACT_TICK) begin
         line_sel = chan;
         op_kind = act;
         tick_cnt = 0;
         bit_pos = 0;
         if (act == owbm_pkg::ACT_RESET) begin
            presence_seen = 1'b0;
            shift_reg = '0;
            bus_phase = BUS_RST_LOW;
         end else begin
            shift_reg = (act == owbm_pkg::ACT_WRITE) ? wbyte : 8'h00;
            bus_phase = BUS_SLOT_LOW;
         end
      end
      if (bus_phase != BUS_IDLE) begin
         r.busy_res = 1'b1;
         r.drive_low = (bus_phase == BUS_RST_LOW || bus_phase == BUS_SLOT_LOW);
         if (bus_phase == BUS_RST_REL && tick_cnt == timing[owbm_pkg::REG_PRESENCE_SAMPLE])
            presence_seen = ~level;
         if (bus_phase == BUS_SLOT_REL && op_kind == owbm_pkg::ACT_READ &&
             tick_cnt == timing[owbm_pkg::REG_READ_SAMPLE])
            shift_reg[bit_pos] = level;
         tick_cnt = (tick_cnt + 1) & 'h1FFF;
         if (tick_cnt >= phase_ticks(bus_phase)) begin
            if (leave_phase()) begin
               r.done_res = 1'b1;
               if (op_kind == owbm_pkg::ACT_RESET) r.presence = presence_seen;
               if (op_kind == owbm_pkg::ACT_READ) r.read_data = shift_reg;
            end
         end
      end
      r.active_channel = line_sel;
      return r;
   endfunction

   task automatic note_failure(input string what);
      failures++;
      $display("%0t ns: result %0d: %s", $time, results_seen, what);
   endtask

   task automatic send_tick(input logic [1:0] act, input logic [7:0] wbyte, input logic chan,
                            input logic level, input logic typed,
                            input owbm_pkg::result_type want);
      owbm_pkg::result_type predicted;
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.action <= act;
      req_if.write_byte <= wbyte;
      req_if.channel <= chan;
      req_if.line_level <= level;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = predict_tick(act, wbyte, chan, level);
      if (predicted.done_res) ops_finished++;
      pending_bus_results.push_back(typed ? want : predicted);
      ticks_sent++;
   endtask

   task automatic load_timing(input owbm_pkg::reg_array_type values);
      int idx;
      for (idx = 0; idx < owbm_pkg::NumRegs; idx++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= IndexBits'(idx);
         csr_if.data <= values[idx];
         @(posedge clock);
         while (!csr_if.ready) @(posedge clock);
         timing[idx] = values[idx];
      end
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   // Ticks the bus until the current operation is over, then lets the results drain.
   task automatic settle_bus();
      while (bus_phase != BUS_IDLE)
         send_tick(owbm_pkg::ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0,
                   Predicted);
      req_if.valid <= 1'b0;
      while (pending_bus_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int k;
      logic [1:0] act;
      logic [7:0] wbyte;
      for (k = 0; k < count; k++) begin
         if (k == count / 2) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
            while (pending_bus_results.size() != 0) @(posedge clock);
         end
         // Mostly ticks while an operation runs, with a few commands that it must ignore.
         if (bus_phase == BUS_IDLE)
            act = ($urandom_range(99) < 85) ? 2'($urandom_range(1, 3)) : owbm_pkg::ACT_TICK;
         else
            act = ($urandom_range(99) < 90) ? owbm_pkg::ACT_TICK : 2'($urandom);
         case ($urandom_range(9))
            0: wbyte = 8'h00;
            1: wbyte = 8'hFF;
            default: wbyte = 8'($urandom);
         endcase
         send_tick(act, wbyte, 1'($urandom), 1'($urandom), 1'b0, Predicted);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      owbm_pkg::result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (pending_bus_results.size() == 0) begin
            note_failure("result arrived with nothing expected");
         end else begin
            want = pending_bus_results.pop_front();
            if (rsp_if.drive_low !== want.drive_low)
               note_failure($sformatf("drive_low %0b, expected %0b",
                                      rsp_if.drive_low, want.drive_low));
            if (rsp_if.active_channel !== want.active_channel)
               note_failure($sformatf("active_channel %0b, expected %0b",
                                      rsp_if.active_channel, want.active_channel));
            if (rsp_if.busy_res !== want.busy_res)
               note_failure($sformatf("busy_res %0b, expected %0b",
                                      rsp_if.busy_res, want.busy_res));
            if (rsp_if.done_res !== want.done_res)
               note_failure($sformatf("done_res %0b, expected %0b",
                                      rsp_if.done_res, want.done_res));
            if (rsp_if.presence !== want.presence)
               note_failure($sformatf("presence %0b, expected %0b",
                                      rsp_if.presence, want.presence));
            if (rsp_if.read_data !== want.read_data)
               note_failure($sformatf("read_data %02h, expected %02h",
                                      rsp_if.read_data, want.read_data));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Timed out after %0d cycles without a transfer.", IdleLimit);
         $display("[onewire_bus_master_timing_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      owbm_pkg::reg_array_type setting;
      int pass;
      int row;
      int idx;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.action <= owbm_pkg::ACT_TICK;
      req_if.write_byte <= '0;
      req_if.channel <= 1'b0;
      req_if.line_level <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      setting = '{default: '0};
      load_timing(setting);
      for (row = 0; row < $size(Script); row++)
         send_tick(Script[row].action, Script[row].write_byte, Script[row].channel,
                   Script[row].line_level, Script[row].typed, Script[row].want);
      settle_bus();

      for (pass = 0; pass < 8; pass++) begin
         case (pass)
            0: setting = '{default: '0};
            3: begin
               // Sample points placed past the end of their windows.
               for (idx = 0; idx < owbm_pkg::NumRegs; idx++)
                  setting[idx] = owbm_pkg::timer_type'($urandom_range(8));
               setting[owbm_pkg::REG_PRESENCE_WINDOW] = owbm_pkg::timer_type'($urandom_range(4));
               setting[owbm_pkg::REG_PRESENCE_SAMPLE] =
                  owbm_pkg::timer_type'($urandom_range(5, 20));
               setting[owbm_pkg::REG_SLOT] = owbm_pkg::timer_type'($urandom_range(4));
               setting[owbm_pkg::REG_READ_SAMPLE] = owbm_pkg::timer_type'($urandom_range(5, 20));
            end
            5: setting = owbm_pkg::RegDefaults;
            default: begin
               for (idx = 0; idx < owbm_pkg::NumRegs; idx++)
                  setting[idx] = owbm_pkg::timer_type'($urandom_range(pass < 4 ? 12 : 24));
            end
         endcase
         load_timing(setting);
         case (pass % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 51; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 51; end
            default: begin gap_pct = 10; stall_pct = 10; end
         endcase
         run_random(80);
         settle_bus();
      end

      // Longest values on every register that a write of a zero byte leaves unused.
      setting = '{default: '1};
      setting[owbm_pkg::REG_SLOT] = owbm_pkg::timer_type'(3);
      setting[owbm_pkg::REG_RECOVERY] = owbm_pkg::timer_type'(2);
      load_timing(setting);
      gap_pct = 0;
      stall_pct = 0;
      send_tick(owbm_pkg::ACT_WRITE, 8'h00, 1'($urandom), 1'($urandom), 1'b0, Predicted);
      settle_bus();

      req_if.valid <= 1'b0;
      while (pending_bus_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Covered %0d ticks under %0d timing settings; %0d bus operations finished.",
               ticks_sent, settings_used, ops_finished);
      $display("Checked %0d results, %0d field mismatches.", results_seen, failures);
      if (failures == 0) begin
         $display("[onewire_bus_master_timing_unit] OK");
      end else begin
         $display("[onewire_bus_master_timing_unit] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/owbm_pkg.sv
rtl/core/owbm_if.sv
rtl/core/owbm_csr.sv
rtl/core/owbm_core.sv
rtl/core/onewire_bus_master_timing_unit.sv
bench/onewire_bus_master_timing_unit_tb.sv
